@@ src/eip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package eip_pkg;

    localparam int unsigned ETH_HEADER_BYTES = 14;
    localparam int unsigned MIN_HDR_BYTES    = 20;

    localparam int unsigned OUT_DATA_W = 208;
    localparam int unsigned OUT_USER_W = 4;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_ZERO = 8'd0;

    typedef enum logic [2:0] {
        L4_TCP     = 3'd0,
        L4_UDP     = 3'd1,
        L4_ICMP    = 3'd2,
        L4_ZERO    = 3'd3,
        L4_UNKNOWN = 3'd4
    } t_l4_kind;

endpackage

`default_nettype wire

@@ src/eth_ipv4_l4_header_parser_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Parses a captured Ethernet frame arriving one byte per transfer (tlast on the
// final byte) and emits one header summary transfer after the last byte. A byte
// is taken every cycle unless input stalls as described below; once accepted,
// the last byte is loaded into the input register, and from there into the
// result register through the offset-compare and capture logic, which presents
// the summary. Input keeps flowing while a summary waits, and stalls only
// while a last byte sits in the input register behind an untaken summary.
// IPv4 layout is applied whatever the ether type; fields never reached read 0.
module eth_ipv4_l4_header_parser_core
    import eip_pkg::*;
#(
    parameter int unsigned ETH_HDR_BYTES = ETH_HEADER_BYTES
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // data_byte
    input  wire logic                  s_axis_tlast,   // last_byte

    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // frame_length, eth_type, src_addr, dst_addr, sport, dport,
    // seq_num, ack_num, pay_len
    output      logic [OUT_DATA_W-1:0] m_axis_tdata,
    // l4_kind, header_valid
    output      logic [OUT_USER_W-1:0] m_axis_tuser
);

    localparam logic [15:0] ETH_OFS = 16'(ETH_HDR_BYTES);
    localparam logic [5:0]  MIN_HB  = 6'(MIN_HDR_BYTES);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // frame state
    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_type_word,  n_type_word;
    logic [5:0]  r_ip_hdr,     n_ip_hdr;
    logic [15:0] r_ip_total,   n_ip_total;
    logic [7:0]  r_proto,      n_proto;
    logic [31:0] r_src_ip,     n_src_ip;
    logic [31:0] r_dst_ip,     n_dst_ip;
    logic [15:0] r_sport,      n_sport;
    logic [15:0] r_dport,      n_dport;
    logic [31:0] r_seq,        n_seq;
    logic [31:0] r_ack,        n_ack;
    logic [7:0]  r_l4_hdr,     n_l4_hdr;

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic        w_adv;
    logic        w_step;
    logic [15:0] w_k_ip;
    logic [15:0] w_l4_ofs;
    logic [15:0] w_k_l4;

    t_l4_kind    w_kind;
    logic [5:0]  w_tcp_bytes;
    logic [6:0]  w_hdrs;
    logic [15:0] w_sp, w_dp, w_plen;
    logic [31:0] w_sq, w_ak;
    logic        w_valid;

    assign w_adv         = !r_in_last || !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    assign w_k_ip   = r_byte_count - ETH_OFS;
    assign w_l4_ofs = ETH_OFS + {10'd0, n_ip_hdr};
    assign w_k_l4   = r_byte_count - w_l4_ofs;

    always_comb begin
        n_byte_count = r_byte_count;
        n_type_word  = r_type_word;
        n_ip_hdr     = r_ip_hdr;
        n_ip_total   = r_ip_total;
        n_proto      = r_proto;
        n_src_ip     = r_src_ip;
        n_dst_ip     = r_dst_ip;
        n_sport      = r_sport;
        n_dport      = r_dport;
        n_seq        = r_seq;
        n_ack        = r_ack;
        n_l4_hdr     = r_l4_hdr;
        if (r_byte_count != 16'hFFFF) begin
            if (r_byte_count == 16'd12 || r_byte_count == 16'd13) begin
                n_type_word = {r_type_word[7:0], r_in_byte};
            end
            if (r_byte_count >= ETH_OFS) begin
                if (w_k_ip == 16'd0) begin
                    n_ip_hdr = {r_in_byte[3:0], 2'b00};
                end else if (w_k_ip == 16'd2 || w_k_ip == 16'd3) begin
                    n_ip_total = {r_ip_total[7:0], r_in_byte};
                end else if (w_k_ip == 16'd9) begin
                    n_proto = r_in_byte;
                end else if (w_k_ip >= 16'd12 && w_k_ip <= 16'd15) begin
                    n_src_ip = {r_src_ip[23:0], r_in_byte};
                end else if (w_k_ip >= 16'd16 && w_k_ip <= 16'd19) begin
                    n_dst_ip = {r_dst_ip[23:0], r_in_byte};
                end
            end
            if (r_byte_count >= w_l4_ofs) begin
                if (w_k_l4 <= 16'd1) begin
                    n_sport = {r_sport[7:0], r_in_byte};
                end else if (w_k_l4 <= 16'd3) begin
                    n_dport = {r_dport[7:0], r_in_byte};
                end else if (w_k_l4 <= 16'd7) begin
                    n_seq = {r_seq[23:0], r_in_byte};
                end else if (w_k_l4 <= 16'd11) begin
                    n_ack = {r_ack[23:0], r_in_byte};
                end else if (w_k_l4 == 16'd12) begin
                    n_l4_hdr = r_in_byte;
                end
            end
            n_byte_count = r_byte_count + 16'd1;
        end
    end

    assign w_tcp_bytes = {n_l4_hdr[7:4], 2'b00};
    assign w_hdrs      = {1'b0, n_ip_hdr} + {1'b0, w_tcp_bytes};

    always_comb begin
        case (n_proto)
            PROTO_TCP:  w_kind = L4_TCP;
            PROTO_UDP:  w_kind = L4_UDP;
            PROTO_ICMP: w_kind = L4_ICMP;
            PROTO_ZERO: w_kind = L4_ZERO;
            default:    w_kind = L4_UNKNOWN;
        endcase
    end

    always_comb begin
        w_sp    = '0;
        w_dp    = '0;
        w_sq    = '0;
        w_ak    = '0;
        w_plen  = '0;
        w_valid = (n_ip_hdr >= MIN_HB);
        case (w_kind)
            L4_TCP: begin
                w_sp = n_sport;
                w_dp = n_dport;
                w_sq = n_seq;
                w_ak = n_ack;
                if (w_tcp_bytes < MIN_HB) begin
                    w_valid = 1'b0;
                end
                if (n_ip_total >= {9'd0, w_hdrs}) begin
                    w_plen = n_ip_total - {9'd0, w_hdrs};
                end else begin
                    w_valid = 1'b0;
                end
            end
            L4_UDP: begin
                w_sp   = n_sport;
                w_dp   = n_dport;
                w_plen = n_seq[31:16];
            end
            default: begin
                w_plen = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_step && r_in_last)) begin
            r_byte_count <= '0;
            r_type_word  <= '0;
            r_ip_hdr     <= '0;
            r_ip_total   <= '0;
            r_proto      <= '0;
            r_src_ip     <= '0;
            r_dst_ip     <= '0;
            r_sport      <= '0;
            r_dport      <= '0;
            r_seq        <= '0;
            r_ack        <= '0;
            r_l4_hdr     <= '0;
        end else if (w_step) begin
            r_byte_count <= n_byte_count;
            r_type_word  <= n_type_word;
            r_ip_hdr     <= n_ip_hdr;
            r_ip_total   <= n_ip_total;
            r_proto      <= n_proto;
            r_src_ip     <= n_src_ip;
            r_dst_ip     <= n_dst_ip;
            r_sport      <= n_sport;
            r_dport      <= n_dport;
            r_seq        <= n_seq;
            r_ack        <= n_ack;
            r_l4_hdr     <= n_l4_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_last) begin
            r_out_data <= {w_plen, w_ak, w_sq, w_dp, w_sp,
                           n_dst_ip, n_src_ip, n_type_word, n_byte_count};
            r_out_user <= {w_valid, w_kind};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

@@ test/eth_ipv4_l4_header_parser_core_checker.sv @@
`timescale 1ns / 1ps

module eth_ipv4_l4_header_parser_core_checker
    import eip_pkg::*;
#(
    parameter int unsigned ETH_HDR_BYTES = ETH_HEADER_BYTES
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [7:0]            i_s_tdata,
    input  wire logic                  i_s_tlast,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic [OUT_USER_W-1:0] i_m_tuser,
    output      int                    o_pending,
    output      int                    o_fail_count
);

    typedef struct {
        logic [15:0] frame_length;
        logic [15:0] eth_type;
        t_l4_kind    kind;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] pay_len;
        logic        header_valid;
    } t_hdr_summary;

    // running capture of the frame in progress
    logic [15:0] cap_count;
    logic [15:0] cap_etype;
    logic [5:0]  cap_ip_hdr;
    logic [15:0] cap_ip_total;
    logic [7:0]  cap_proto;
    logic [31:0] cap_src_ip;
    logic [31:0] cap_dst_ip;
    logic [15:0] cap_sport;
    logic [15:0] cap_dport;
    logic [31:0] cap_seq;
    logic [31:0] cap_ack;
    logic [7:0]  cap_l4_byte;

    t_hdr_summary summary_q[$];
    t_hdr_summary want;
    int           fails = 0;

    initial o_pending = 0;
    initial o_fail_count = 0;

    task automatic clear_capture();
        cap_count    = '0;
        cap_etype    = '0;
        cap_ip_hdr   = '0;
        cap_ip_total = '0;
        cap_proto    = '0;
        cap_src_ip   = '0;
        cap_dst_ip   = '0;
        cap_sport    = '0;
        cap_dport    = '0;
        cap_seq      = '0;
        cap_ack      = '0;
        cap_l4_byte  = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int unsigned  pos;
        int unsigned  k;
        int unsigned  tcp_bytes;
        int unsigned  hdrs;
        t_hdr_summary s;
        pos = 32'(cap_count);
        if (pos < 32'hFFFF) begin
            if (pos == 12 || pos == 13)
                cap_etype = {cap_etype[7:0], b};
            if (pos >= ETH_HDR_BYTES) begin
                k = pos - ETH_HDR_BYTES;
                if (k == 0)
                    cap_ip_hdr = {b[3:0], 2'b00};
                else if (k == 2 || k == 3)
                    cap_ip_total = {cap_ip_total[7:0], b};
                else if (k == 9)
                    cap_proto = b;
                else if (k >= 12 && k <= 15)
                    cap_src_ip = {cap_src_ip[23:0], b};
                else if (k >= 16 && k <= 19)
                    cap_dst_ip = {cap_dst_ip[23:0], b};
            end
            if (pos >= ETH_HDR_BYTES + 32'(cap_ip_hdr)) begin
                k = pos - (ETH_HDR_BYTES + 32'(cap_ip_hdr));
                if (k <= 1)
                    cap_sport = {cap_sport[7:0], b};
                else if (k <= 3)
                    cap_dport = {cap_dport[7:0], b};
                else if (k <= 7)
                    cap_seq = {cap_seq[23:0], b};
                else if (k <= 11)
                    cap_ack = {cap_ack[23:0], b};
                else if (k == 12)
                    cap_l4_byte = b;
            end
            cap_count = 16'(pos + 1);
        end
        if (last) begin
            s.frame_length = cap_count;
            s.eth_type     = cap_etype;
            s.src_addr     = cap_src_ip;
            s.dst_addr     = cap_dst_ip;
            s.sport        = '0;
            s.dport        = '0;
            s.seq_num      = '0;
            s.ack_num      = '0;
            s.pay_len      = '0;
            s.header_valid = (cap_ip_hdr >= MIN_HDR_BYTES);
            case (cap_proto)
                PROTO_TCP:  s.kind = L4_TCP;
                PROTO_UDP:  s.kind = L4_UDP;
                PROTO_ICMP: s.kind = L4_ICMP;
                PROTO_ZERO: s.kind = L4_ZERO;
                default:    s.kind = L4_UNKNOWN;
            endcase
            if (s.kind == L4_TCP) begin
                tcp_bytes = 32'({cap_l4_byte[7:4], 2'b00});
                hdrs      = 32'(cap_ip_hdr) + tcp_bytes;
                s.sport   = cap_sport;
                s.dport   = cap_dport;
                s.seq_num = cap_seq;
                s.ack_num = cap_ack;
                if (tcp_bytes < MIN_HDR_BYTES)
                    s.header_valid = 1'b0;
                if (32'(cap_ip_total) >= hdrs) begin
                    s.pay_len = 16'(32'(cap_ip_total) - hdrs);
                end else begin
                    s.header_valid = 1'b0;
                end
            end else if (s.kind == L4_UDP) begin
                s.sport   = cap_sport;
                s.dport   = cap_dport;
                s.pay_len = cap_seq[31:16];
            end
            summary_q.push_back(s);
            clear_capture();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_capture();
            summary_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                absorb_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (summary_q.size() == 0) begin
                    $error("summary transfer with no frame end pending");
                    fails++;
                end else begin
                    want = summary_q.pop_front();
                    check_field("frame_length", 32'(want.frame_length),
                                32'(i_m_tdata[15:0]));
                    check_field("eth_type", 32'(want.eth_type), 32'(i_m_tdata[31:16]));
                    check_field("src_addr", want.src_addr, i_m_tdata[63:32]);
                    check_field("dst_addr", want.dst_addr, i_m_tdata[95:64]);
                    check_field("sport", 32'(want.sport), 32'(i_m_tdata[111:96]));
                    check_field("dport", 32'(want.dport), 32'(i_m_tdata[127:112]));
                    check_field("seq_num", want.seq_num, i_m_tdata[159:128]);
                    check_field("ack_num", want.ack_num, i_m_tdata[191:160]);
                    check_field("pay_len", 32'(want.pay_len), 32'(i_m_tdata[207:192]));
                    check_field("l4_kind", 32'(want.kind), 32'(i_m_tuser[2:0]));
                    check_field("header_valid", 32'(want.header_valid),
                                32'(i_m_tuser[3]));
                end
            end
        end
        o_pending    <= summary_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ test/eth_ipv4_l4_header_parser_core_tb.sv @@
`timescale 1ns / 1ps

module eth_ipv4_l4_header_parser_core_tb;
    import eip_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_BYTES = 1150;
    localparam int RANDOM_MIN_FRAMES = 8;
    localparam int unsigned ETH_HDR = ETH_HEADER_BYTES;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tready = 1'b0;
    wire logic             s_tready;
    wire logic             m_tvalid;
    wire logic [OUT_DATA_W-1:0] m_tdata;
    wire logic [OUT_USER_W-1:0] m_tuser;

    int          pending;
    int          fail_count;
    int          cycle_cnt = 0;
    int          rx_hold = 0;
    bit          gaps_on = 1'b1;
    int          sent_bytes = 0;
    int          rand_frames = 0;
    logic [7:0]  frame_q[$];

    always #10 clk = ~clk;

    eth_ipv4_l4_header_parser_core #(
        .ETH_HDR_BYTES (ETH_HDR)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    eth_ipv4_l4_header_parser_core_checker #(
        .ETH_HDR_BYTES (ETH_HDR)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("eth_ipv4_l4_header_parser_core verification failed");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge clk) begin
        if (!gaps_on) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // transport layout goes in first so the IP fields win where a short IHL overlaps
    task automatic build_frame(input logic [15:0] etype, input logic [3:0] ihl,
                               input logic [7:0] proto, input logic [3:0] doff,
                               input int tail, input int cut, input bit len_ok);
        int          l4_off;
        int          l4_len;
        int          n;
        int          i;
        logic [15:0] tot;
        logic [15:0] udp_len;
        l4_off = 14 + int'(ihl) * 4;
        if (proto == PROTO_TCP)
            l4_len = (int'(doff) * 4 > 13) ? int'(doff) * 4 : 13;
        else
            l4_len = 8;
        n = (l4_off + l4_len > 34) ? l4_off + l4_len : 34;
        n = n + tail;
        frame_q.delete();
        for (i = 0; i < n; i++)
            frame_q.push_back(8'($urandom_range(0, 255)));
        tot     = len_ok ? 16'(n - 14) : 16'($urandom_range(0, 65535));
        udp_len = len_ok ? 16'(n - l4_off) : 16'($urandom_range(0, 65535));
        if (proto == PROTO_UDP) begin
            frame_q[l4_off + 4] = udp_len[15:8];
            frame_q[l4_off + 5] = udp_len[7:0];
        end else if (proto == PROTO_TCP) begin
            frame_q[l4_off + 12] = {doff, 4'($urandom_range(0, 15))};
        end
        frame_q[12] = etype[15:8];
        frame_q[13] = etype[7:0];
        frame_q[14] = {4'h4, ihl};
        frame_q[16] = tot[15:8];
        frame_q[17] = tot[7:0];
        frame_q[23] = proto;
        if (cut > 0)
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
    endtask

    task automatic noise_frame(input int n);
        int i;
        frame_q.delete();
        for (i = 0; i < n; i++)
            frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame();
        bit quiet;
        int i;
        quiet = !gaps_on || ($urandom_range(0, 3) == 0);
        for (i = 0; i < frame_q.size(); i++) begin
            if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_q[i];
            s_tlast  <= (i == frame_q.size() - 1);
            do @(posedge clk); while (!s_tready);
        end
        sent_bytes += frame_q.size();
    endtask

    task automatic drain_summaries();
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 5))
            0, 1:    return PROTO_TCP;
            2:       return PROTO_UDP;
            3:       return PROTO_ICMP;
            4:       return PROTO_ZERO;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [3:0] ihl;
        logic [3:0] doff;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two single-byte frames, then one that ends inside the ether type
        noise_frame(1); frame_q[0] = 8'hFF; send_frame();
        noise_frame(1); frame_q[0] = 8'h00; send_frame();
        noise_frame(13); send_frame();
        build_frame(16'h0800, 4'd5, PROTO_TCP, 4'd5, 4, 0, 1'b1); send_frame();
        build_frame(16'hFFFF, 4'd15, PROTO_TCP, 4'd15, 0, 0, 1'b1); send_frame();
        build_frame(16'h0000, 4'd5, PROTO_TCP, 4'd5, 2, 0, 1'b1);
        frame_q[16] = 8'h00; frame_q[17] = 8'h00;   // total length below headers
        send_frame();
        build_frame(16'h0800, 4'd5, PROTO_TCP, 4'd4, 3, 0, 1'b1); send_frame();
        build_frame(16'h0800, 4'd5, PROTO_UDP, 4'd0, 3, 0, 1'b1); send_frame();
        build_frame(16'h0800, 4'd5, PROTO_ICMP, 4'd0, 2, 0, 1'b1); send_frame();
        build_frame(16'h0800, 4'd5, PROTO_ZERO, 4'd0, 0, 0, 1'b1); send_frame();
        build_frame(16'h0800, 4'd5, 8'hFF, 4'd0, 1, 0, 1'b1); send_frame();
        build_frame(16'h0800, 4'd0, PROTO_TCP, 4'd5, 2, 0, 1'b1); send_frame();
        build_frame(16'h0800, 4'd4, PROTO_UDP, 4'd0, 2, 0, 1'b1); send_frame();
        build_frame(16'h0800, 4'd5, PROTO_TCP, 4'd5, 0, 40, 1'b1); send_frame();
        build_frame(16'h86DD, 4'd6, PROTO_UDP, 4'd0, 5, 0, 1'b0); send_frame();

        s_tvalid <= 1'b0;
        drain_summaries();

        while (sent_bytes < RANDOM_BYTES || rand_frames < RANDOM_MIN_FRAMES) begin
            if (sent_bytes >= RANDOM_BYTES - 200 && rand_frames >= RANDOM_MIN_FRAMES - 8)
                gaps_on = 1'b0;
            if ($urandom_range(0, 9) < 2) begin
                noise_frame($urandom_range(1, 60));
            end else begin
                ihl  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 4))
                     : ($urandom_range(0, 1) == 0) ? 4'd5 : 4'($urandom_range(5, 15));
                doff = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 4))
                     : ($urandom_range(0, 1) == 0) ? 4'd5 : 4'($urandom_range(5, 15));
                build_frame(($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                            : 16'h0800,
                            ihl, pick_proto(), doff, $urandom_range(0, 12),
                            ($urandom_range(0, 5) == 0) ? $urandom_range(1, 60) : 0,
                            $urandom_range(0, 4) != 0);
            end
            send_frame();
            rand_frames++;
        end

        s_tvalid <= 1'b0;

        drain_summaries();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("eth_ipv4_l4_header_parser_core verification clean");
        end else begin
            $display("eth_ipv4_l4_header_parser_core verification failed");
        end
        $finish;
    end

endmodule
